// ===== hdl/block_compare_run_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Block compare run tracker assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_COMPARE_RUN_TRACKER_UNIT_ASSERT_SVH
`define BLOCK_COMPARE_RUN_TRACKER_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define CRT_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("crt assertion failed");

// Whenever the antecedent holds, the consequent holds at the same edge.
`define CRT_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crt assertion failed");

`endif

// ===== hdl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// Block compare run tracker package
// Item types, configuration layout, report kinds and register indexes.
// ----------------------------------------------------------------------------
package crt_pkg;

   localparam int FIELD_W     = 17;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

   localparam logic [1:0] KIND_GOOD   = 2'd0;
   localparam logic [1:0] KIND_BAD    = 2'd1;
   localparam logic [1:0] KIND_TOTALS = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_WORDS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_WORDS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMESTAMP_MODE   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_START_LBA = 2'd3;

   localparam logic [10:0] BLOCK_WORDS_RESET = 11'd128;

   typedef struct packed {
      logic [31:0] expected_word;
      logic [31:0] received_word;
      logic        end_of_record;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FIELD_W-1:0] start_block;
      logic [FIELD_W-1:0] run_length;
      logic [31:0]        start_lba;
      logic [FIELD_W-1:0] bad_total;
      logic [FIELD_W-1:0] good_total;
      logic [FIELD_W-1:0] zero_total;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [10:0] block_words;
      logic [9:0]  prefix_words;
      logic        timestamp_mode;
      logic [31:0] record_start_lba;
   } cfg_type;

   // Reports caused by one word: a run ended by a completed block, the run
   // closed at end of record, and the record totals, in that order.
   typedef struct packed {
      logic [2:0]         valid;
      rsp_item_type [2:0] item;
   } cand_type;

endpackage

// ===== hdl/crt_track.sv =====
// ----------------------------------------------------------------------------
// Block compare run tracker core
// Per-word compare, block completion, run bookkeeping and record totals.
// ----------------------------------------------------------------------------
`include "block_compare_run_tracker_unit_assert.svh"

module crt_track
   import crt_pkg::*;
#(
   parameter int MAX_BLOCK_WORDS   = 1024,
   parameter int MAX_RECORD_BLOCKS = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_item_type in_item,
   input  logic         advance,
   output cand_type     cand
);

   localparam int WI_W  = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
   localparam int CNT_W = $clog2(MAX_RECORD_BLOCKS + 2);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORD_BLOCKS);
   localparam logic [CNT_W-1:0] MAX_BN  = CNT_W'(MAX_RECORD_BLOCKS + 1);
   localparam logic [31:0]      MAX_BW  = 32'(MAX_BLOCK_WORDS);

   logic [WI_W-1:0]  word_index_ff, word_index_in;
   logic             mismatch_ff, mismatch_in;
   logic             nonzero_ff, nonzero_in;
   logic [CNT_W-1:0] block_number_ff, block_number_in;
   logic [CNT_W-1:0] good_start_ff, good_start_in;
   logic [CNT_W-1:0] bad_start_ff, bad_start_in;
   logic [CNT_W-1:0] bad_count_ff, bad_count_in;
   logic [CNT_W-1:0] good_count_ff, good_count_in;
   logic [CNT_W-1:0] zero_count_ff, zero_count_in;

   logic [31:0]      bw32, eff, wi32;
   logic             ts_hit, mism, nonz, done;
   logic [CNT_W-1:0] start, good_upd, bad_upd, bn_upd;
   logic [CNT_W-1:0] bad_cnt_upd, good_cnt_upd, zero_cnt_upd;

   function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
      logic [CNT_W+FIELD_W-1:0] ext;
      ext = {{FIELD_W{1'b0}}, v};
      return ext[FIELD_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v < MAX_CNT) ? v + CNT_W'(1) : v;
   endfunction

   function automatic rsp_item_type run_item(input logic [1:0] kind,
                                             input logic [CNT_W-1:0] rs,
                                             input logic [CNT_W-1:0] bn,
                                             input logic [31:0] lba);
      rsp_item_type r;
      logic [CNT_W+31:0] ext;
      ext           = {32'd0, rs};
      r             = '0;
      r.kind        = kind;
      r.start_block = to_field(rs);
      r.run_length  = to_field(bn - rs);
      r.start_lba   = lba + ext[31:0] - 32'd1;
      return r;
   endfunction

   always_comb begin
      bw32 = {21'd0, cfg.block_words};
      if (bw32 == 32'd0) begin
         eff = 32'd1;
      end else if (bw32 > MAX_BW) begin
         eff = MAX_BW;
      end else begin
         eff = bw32;
      end
      wi32   = {{(32-WI_W){1'b0}}, word_index_ff};
      ts_hit = cfg.timestamp_mode && (wi32 == {22'd0, cfg.prefix_words});
      mism   = mismatch_ff ||
               (!ts_hit && (in_item.expected_word != in_item.received_word));
      nonz   = nonzero_ff || (in_item.received_word != 32'd0);
      done   = (wi32 + 32'd1) >= eff;
      start  = (block_number_ff > MAX_CNT) ? MAX_CNT : block_number_ff;

      good_upd     = good_start_ff;
      bad_upd      = bad_start_ff;
      bn_upd       = block_number_ff;
      bad_cnt_upd  = bad_count_ff;
      good_cnt_upd = good_count_ff;
      zero_cnt_upd = zero_count_ff;
      cand         = '0;

      if (done) begin
         if (!mism) begin
            good_cnt_upd = sat_inc(good_count_ff);
            if (good_start_ff == '0) begin
               good_upd = start;
            end
            if (bad_start_ff != '0) begin
               cand.valid[0] = 1'b1;
               cand.item[0]  = run_item(KIND_BAD, bad_start_ff, block_number_ff,
                                        cfg.record_start_lba);
               bad_upd       = '0;
            end
         end else begin
            bad_cnt_upd = sat_inc(bad_count_ff);
            if (!nonz) begin
               zero_cnt_upd = sat_inc(zero_count_ff);
            end
            if (bad_start_ff == '0) begin
               bad_upd = start;
            end
            if (good_start_ff != '0) begin
               cand.valid[0] = 1'b1;
               cand.item[0]  = run_item(KIND_GOOD, good_start_ff, block_number_ff,
                                        cfg.record_start_lba);
               good_upd      = '0;
            end
         end
         if (block_number_ff < MAX_BN) begin
            bn_upd = block_number_ff + CNT_W'(1);
         end
      end

      if (in_item.end_of_record) begin
         if (bad_upd != '0) begin
            cand.valid[1] = 1'b1;
            cand.item[1]  = run_item(KIND_BAD, bad_upd, bn_upd, cfg.record_start_lba);
         end else if (good_upd != '0) begin
            cand.valid[1] = 1'b1;
            cand.item[1]  = run_item(KIND_GOOD, good_upd, bn_upd, cfg.record_start_lba);
         end
         cand.valid[2]           = 1'b1;
         cand.item[2].kind       = KIND_TOTALS;
         cand.item[2].bad_total  = to_field(bad_cnt_upd);
         cand.item[2].good_total = to_field(good_cnt_upd);
         cand.item[2].zero_total = to_field(zero_cnt_upd);
         cand.item[2].last       = 1'b1;
      end

      word_index_in   = word_index_ff;
      mismatch_in     = mismatch_ff;
      nonzero_in      = nonzero_ff;
      block_number_in = block_number_ff;
      good_start_in   = good_start_ff;
      bad_start_in    = bad_start_ff;
      bad_count_in    = bad_count_ff;
      good_count_in   = good_count_ff;
      zero_count_in   = zero_count_ff;
      if (advance) begin
         if (in_item.end_of_record) begin
            word_index_in   = '0;
            mismatch_in     = 1'b0;
            nonzero_in      = 1'b0;
            block_number_in = CNT_W'(1);
            good_start_in   = '0;
            bad_start_in    = '0;
            bad_count_in    = '0;
            good_count_in   = '0;
            zero_count_in   = '0;
         end else begin
            word_index_in   = done ? '0 : word_index_ff + WI_W'(1);
            mismatch_in     = done ? 1'b0 : mism;
            nonzero_in      = done ? 1'b0 : nonz;
            block_number_in = bn_upd;
            good_start_in   = good_upd;
            bad_start_in    = bad_upd;
            bad_count_in    = bad_cnt_upd;
            good_count_in   = good_cnt_upd;
            zero_count_in   = zero_cnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff   <= '0;
         mismatch_ff     <= 1'b0;
         nonzero_ff      <= 1'b0;
         block_number_ff <= CNT_W'(1);
         good_start_ff   <= '0;
         bad_start_ff    <= '0;
         bad_count_ff    <= '0;
         good_count_ff   <= '0;
         zero_count_ff   <= '0;
      end else begin
         word_index_ff   <= word_index_in;
         mismatch_ff     <= mismatch_in;
         nonzero_ff      <= nonzero_in;
         block_number_ff <= block_number_in;
         good_start_ff   <= good_start_in;
         bad_start_ff    <= bad_start_in;
         bad_count_ff    <= bad_count_in;
         good_count_ff   <= good_count_in;
         zero_count_ff   <= zero_count_in;
      end
   end

   // A good run and a bad run are never open together, and an open run
   // never starts past the current block.
   `CRT_ASSERT_ALWAYS(a_one_run_open, (good_start_ff == '0) || (bad_start_ff == '0))
   `CRT_ASSERT_ALWAYS(a_run_start_order, (good_start_ff <= block_number_ff) && (bad_start_ff <= block_number_ff))

endmodule

// ===== hdl/crt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Block compare run tracker output queue
// Small report queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`include "block_compare_run_tracker_unit_assert.svh"

module crt_out_fifo
   import crt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push,
   input  rsp_item_type [1:0]   push_item,
   input  logic                 pop,
   output logic                 out_valid,
   output rsp_item_type         out_item,
   output logic [OUT_CNT_W-1:0] count
);

   rsp_item_type         mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0] count_ff, count_in;
   logic [OUT_PTR_W-1:0] wr_ptr_next;
   logic [OUT_CNT_W-1:0] push_n;

   assign out_valid   = (count_ff != '0);
   assign out_item    = mem_ff[rd_ptr_ff];
   assign count       = count_ff;
   assign wr_ptr_next = wr_ptr_ff + OUT_PTR_W'(1);

   always_comb begin
      push_n    = OUT_CNT_W'(push[0]) + OUT_CNT_W'(push[1]);
      wr_ptr_in = wr_ptr_ff + push_n[OUT_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + OUT_PTR_W'(pop);
      count_in  = count_ff + push_n - OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push[0]) begin
         mem_ff[wr_ptr_ff] <= push_item[0];
      end
      if (push[1]) begin
         mem_ff[wr_ptr_next] <= push_item[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The producer only pushes when two entries are free.
   `CRT_ASSERT_IMPLY(a_push_room, push != 2'b00, count_ff <= OUT_CNT_W'(OUT_DEPTH - 2))
   `CRT_ASSERT_IMPLY(a_push_order, push[1], push[0])

endmodule

// ===== hdl/block_compare_run_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Block compare run tracker
// Compares a record word by word in blocks and reports good and bad runs.
// ----------------------------------------------------------------------------
// Each word is registered in the input register, and its reports pass through
// the report queue, whose registered head is offered on rsp.
// Throughput: one word per cycle; the input register holds while fewer than
// two entries of the four-entry report queue are free.
// Totals that are the third report of one word wait until the next word.
// Reset is synchronous: registers return to 128, 0, 0, 0, the record clears.
`include "block_compare_run_tracker_unit_assert.svh"

module block_compare_run_tracker_unit
   import crt_pkg::*;
#(
   parameter int MAX_BLOCK_WORDS   = 1024,
   parameter int MAX_RECORD_BLOCKS = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type              cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   req_item_type         in_item_ff, in_item_in;
   logic                 hold_valid_ff, hold_valid_in;
   rsp_item_type         hold_item_ff, hold_item_in;
   cand_type             cand;
   logic                 advance;
   logic [OUT_CNT_W-1:0] fifo_count;
   logic [1:0]           push;
   rsp_item_type [1:0]   push_item;
   logic                 hold_next_v;
   rsp_item_type         hold_next_item;
   logic [3:0]           list_v;
   rsp_item_type [3:0]   list_item;
   logic [2:0]           n;

   assign advance   = in_valid_ff && (fifo_count <= OUT_CNT_W'(OUT_DEPTH - 2));
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BLOCK_WORDS:      cfg_in.block_words      = csr_wdata[10:0];
            CSR_PREFIX_WORDS:     cfg_in.prefix_words     = csr_wdata[9:0];
            CSR_TIMESTAMP_MODE:   cfg_in.timestamp_mode   = csr_wdata[0];
            CSR_RECORD_START_LBA: cfg_in.record_start_lba = csr_wdata[31:0];
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_item_in = req_item;
         end
      end
   end

   crt_track #(
      .MAX_BLOCK_WORDS  (MAX_BLOCK_WORDS),
      .MAX_RECORD_BLOCKS(MAX_RECORD_BLOCKS)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .in_item(in_item_ff),
      .advance(advance),
      .cand   (cand)
   );

   // The held totals go out first. The first two reports of the list are
   // queued; beyond two, the last one is held and the ones between drop.
   always_comb begin
      list_v         = {cand.valid, hold_valid_ff};
      list_item      = {cand.item, hold_item_ff};
      n              = 3'd0;
      push           = 2'b00;
      push_item      = '0;
      hold_next_v    = 1'b0;
      hold_next_item = hold_item_ff;
      for (int i = 0; i < 4; i++) begin
         if (list_v[i]) begin
            if (n == 3'd0) begin
               push[0]      = 1'b1;
               push_item[0] = list_item[i];
            end else if (n == 3'd1) begin
               push[1]      = 1'b1;
               push_item[1] = list_item[i];
            end else begin
               hold_next_v    = 1'b1;
               hold_next_item = list_item[i];
            end
            n = n + 3'd1;
         end
      end
      if (!advance) begin
         push = 2'b00;
      end
      hold_valid_in = advance ? hold_next_v : hold_valid_ff;
      hold_item_in  = advance ? hold_next_item : hold_item_ff;
   end

   crt_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (rsp_valid && !rsp_stall),
      .out_valid(rsp_valid),
      .out_item (rsp_item),
      .count    (fifo_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_words      <= BLOCK_WORDS_RESET;
         cfg_ff.prefix_words     <= '0;
         cfg_ff.timestamp_mode   <= 1'b0;
         cfg_ff.record_start_lba <= '0;
         in_valid_ff             <= 1'b0;
         hold_valid_ff           <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         in_valid_ff   <= in_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      hold_item_ff <= hold_item_in;
   end

   // Only a record's totals are ever held back.
   `CRT_ASSERT_IMPLY(a_hold_is_totals, hold_valid_ff, (hold_item_ff.kind == KIND_TOTALS) && hold_item_ff.last)

endmodule
